[rtl/fpatan_pkg.sv]
// Shared types, constants and arithmetic helpers for the fixed-point atan2 core.
package fpatan_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned DivSteps = 16;
  localparam int unsigned FifoDepth = 2;

  localparam logic [15:0] CStep1  = 16'd35457;
  localparam logic [15:0] CStep2  = 16'd19598;
  localparam logic [15:0] CStep3  = 16'd8898;
  localparam logic [15:0] CHalf14 = 16'd16384;
  localparam logic [15:0] COne15  = 16'd32768;
  localparam logic [7:0]  CStep0Hi = 8'h40;

  typedef struct packed {
    logic [DataW-1:0] ay;
    logic [DataW-1:0] ax;
    logic [2:0]       code;
    logic             zero;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] ratio;
    logic [2:0]       code;
    logic             zero;
  } ratio_t;

  function automatic logic [15:0] qmul16(logic [15:0] a, logic [15:0] b);
    logic [31:0] p;
    p = 32'(a) * 32'(b) + 32'h0000_8000;
    return p[31:16];
  endfunction

  function automatic logic [7:0] axis_base(logic [2:0] code);
    logic [7:0] b;
    unique case (code)
      3'd0: b = 8'h00;
      3'd1: b = 8'h40;
      3'd2: b = 8'h00;
      3'd3: b = 8'hc0;
      3'd4: b = 8'h80;
      3'd5: b = 8'h40;
      3'd6: b = 8'h80;
      default: b = 8'hc0;
    endcase
    return b;
  endfunction

endpackage

[rtl/fpatan_front.sv]
// Front stage: folds each vector into the first octant and registers it.
module fpatan_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [15:0]   y_coord_i,
  input  logic signed [15:0]   x_coord_i,
  output logic                 f_valid_o,
  input  logic                 f_ready_i,
  output fpatan_pkg::item_t    f_item_o
);
  import fpatan_pkg::*;

  logic        valid_q;
  item_t       item_q, item_d;
  logic [15:0] ay, ax;
  logic [2:0]  code;

  always_comb begin
    ax = x_coord_i[15] ? 16'(-x_coord_i) : x_coord_i;
    ay = y_coord_i[15] ? 16'(-y_coord_i) : y_coord_i;
    code = {x_coord_i[15], y_coord_i[15], 1'b0};
    item_d.ay = ay;
    item_d.ax = ax;
    if (ay > ax) begin
      item_d.ay = ax;
      item_d.ax = ay;
      code[0] = 1'b1;
    end
    item_d.code = code;
    item_d.zero = (ax == 16'd0) && (ay == 16'd0);
  end

  assign in_ready_o = !valid_q || f_ready_i;
  assign f_valid_o  = valid_q;
  assign f_item_o   = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

[rtl/fpatan_fifo.sv]
// Short queue that decouples the front stage from the back pipeline.
module fpatan_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  fpatan_pkg::item_t push_item_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output fpatan_pkg::item_t pop_item_o
);
  import fpatan_pkg::*;

  item_t      mem_q [FifoDepth];
  logic [0:0] wr_q, rd_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = count_q != 2'(FifoDepth);
  assign pop_valid_o  = count_q != 2'd0;
  assign pop_item_o   = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(FifoDepth)) else $error("queue count beyond depth");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == $past(count_q) + 2'($past(push)) - 2'($past(pop)))
    else $error("queue count out of step with beats");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'(FifoDepth)) |-> wr_q == rd_q)
    else $error("queue pointers disagree with count");

endmodule

[rtl/fpatan_div.sv]
// Restoring divider pipeline, one quotient bit per stage, giving the Q15 ratio.
module fpatan_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  fpatan_pkg::item_t  item_i,
  output logic               valid_o,
  output fpatan_pkg::ratio_t ratio_o
);
  import fpatan_pkg::*;

  logic        valid_q [DivSteps];
  logic [15:0] rem_q   [DivSteps];
  logic [15:0] ax_q    [DivSteps];
  logic [15:0] quo_q   [DivSteps];
  logic [2:0]  code_q  [DivSteps];
  logic        zero_q  [DivSteps];

  logic [15:0] rem_d [DivSteps];
  logic        ge_d  [DivSteps];

  always_comb begin
    ge_d[0]  = item_i.ay >= item_i.ax;
    rem_d[0] = ge_d[0] ? item_i.ay - item_i.ax : item_i.ay;
    for (int k = 1; k < DivSteps; k++) begin
      ge_d[k]  = {rem_q[k-1], 1'b0} >= {1'b0, ax_q[k-1]};
      rem_d[k] = ge_d[k] ? 16'({rem_q[k-1], 1'b0} - {1'b0, ax_q[k-1]})
                         : 16'({rem_q[k-1], 1'b0});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivSteps; k++) valid_q[k] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int k = 1; k < DivSteps; k++) valid_q[k] <= valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem_d[0];
      ax_q[0]   <= item_i.ax;
      quo_q[0]  <= {15'd0, ge_d[0]};
      code_q[0] <= item_i.code;
      zero_q[0] <= item_i.zero;
      for (int k = 1; k < DivSteps; k++) begin
        rem_q[k]  <= rem_d[k];
        ax_q[k]   <= ax_q[k-1];
        quo_q[k]  <= {quo_q[k-1][14:0], ge_d[k]};
        code_q[k] <= code_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  assign valid_o       = valid_q[DivSteps-1];
  assign ratio_o.ratio = quo_q[DivSteps-1];
  assign ratio_o.code  = code_q[DivSteps-1];
  assign ratio_o.zero  = zero_q[DivSteps-1];

endmodule

[rtl/fpatan_poly.sv]
// Polynomial pipeline for atan of the ratio, octant fix-up and output register.
module fpatan_poly (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  fpatan_pkg::ratio_t ratio_i,
  output logic               valid_o,
  output logic [15:0]        angle_o,
  output logic               both_zero_o
);
  import fpatan_pkg::*;

  logic [4:0]  valid_q;
  ratio_t      r_q [5];
  logic [15:0] s_q [5];
  logic [15:0] angle_q;
  logic        zero_q;
  logic [15:0] ang_pos, ang_sgn;
  logic        odd;

  assign ang_pos = s_q[4];
  assign odd     = ^r_q[4].code;
  assign ang_sgn = odd ? 16'(-ang_pos) : ang_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_q <= {valid_q[3:0], valid_i};
      valid_o <= valid_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0] <= ratio_i;
      s_q[0] <= CStep1 - ({8'd0, ratio_i.ratio[15:8]} * {8'd0, CStep0Hi});
      r_q[1] <= r_q[0];
      s_q[1] <= CStep2 - qmul16(r_q[0].ratio, s_q[0]);
      r_q[2] <= r_q[1];
      s_q[2] <= CStep3 + qmul16(r_q[1].ratio, s_q[1]);
      r_q[3] <= r_q[2];
      s_q[3] <= CHalf14 + qmul16(COne15 - r_q[2].ratio, s_q[2]);
      r_q[4] <= r_q[3];
      s_q[4] <= qmul16(r_q[3].ratio, s_q[3]);
      angle_q <= r_q[4].zero ? 16'd0 : ang_sgn + {axis_base(r_q[4].code), 8'h00};
      zero_q  <= r_q[4].zero;
    end
  end

  assign angle_o     = angle_q;
  assign both_zero_o = zero_q;

endmodule

[rtl/fixed_point_atan2_core.sv]
// Top level of the fixed-point four-quadrant atan2 core.
// Input channel: in_valid_i/in_ready_o with y_coord_i and x_coord_i, signed 16 bits.
// Output channel: out_valid_o/out_ready_i with angle_o, a binary angle of 65536
// counts per turn, and both_zero_o, set with a zero angle for a zero vector.
// Every beat yields exactly one result beat, in order.
// A front stage folds the vector into the first octant and registers it.
// A two-entry queue separates it from the back pipeline, so each side stalls alone.
// The back pipeline holds sixteen divider stages, one quotient bit each, then
// five multiply stages for the polynomial and one output register.
// Throughput is one beat per cycle while out_ready_i stays high, as set by
// the fully pipelined divider.
// When out_valid_o is high and out_ready_i low the whole back pipeline holds; the
// queue and front stage keep taking beats until they fill, then in_ready_o drops.
// Reset clears all valid flags and queue pointers; no result is pending after it.
module fixed_point_atan2_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] y_coord_i,
  input  logic signed [15:0] x_coord_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] angle_o,
  output logic               both_zero_o
);
  import fpatan_pkg::*;

  logic   f_valid, f_ready, q_valid, en, d_valid;
  item_t  f_item, q_item;
  ratio_t d_ratio;
  logic [15:0] angle;

  assign en = !out_valid_o || out_ready_i;

  fpatan_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .y_coord_i, .x_coord_i,
    .f_valid_o(f_valid), .f_ready_i(f_ready), .f_item_o(f_item)
  );

  fpatan_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_valid_i(f_valid), .push_ready_o(f_ready), .push_item_i(f_item),
    .pop_valid_o(q_valid), .pop_ready_i(en), .pop_item_o(q_item)
  );

  fpatan_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(q_valid), .item_i(q_item),
    .valid_o(d_valid), .ratio_o(d_ratio)
  );

  fpatan_poly u_poly (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_valid), .ratio_i(d_ratio),
    .valid_o(out_valid_o), .angle_o(angle), .both_zero_o
  );

  assign angle_o = signed'(angle);

endmodule
